[rtl/imfs_pkg.sv]
// Shared types and constants for the IRC message field splitter.
package imfs_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CLASS_W = 3;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(512);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LIMIT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_LIMIT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PARAMS_LIMIT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TRAILING_LIMIT = CFG_IDX_W'(3);

    typedef enum logic [PHASE_W-1:0] {
        PH_START  = 4'd0,
        PH_PREFIX = 4'd1,
        PH_GAP1   = 4'd2,
        PH_CMD    = 4'd3,
        PH_GAP2   = 4'd4,
        PH_COLON2 = 4'd5,
        PH_PARAMS = 4'd6,
        PH_GAP3   = 4'd7,
        PH_CHOOSE = 4'd8,
        PH_REST   = 4'd9,
        PH_WORD   = 4'd10,
        PH_GAP4   = 4'd11,
        PH_COLON4 = 4'd12,
        PH_ENDED  = 4'd13
    } t_phase;

    localparam int unsigned PH_NUM = 14;

    typedef enum logic [CLASS_W-1:0] {
        CLS_PREFIX   = 3'd0,
        CLS_COMMAND  = 3'd1,
        CLS_PARAMS   = 3'd2,
        CLS_TRAILING = 3'd3,
        CLS_SKIP     = 3'd4,
        CLS_NONE     = 3'd5
    } t_class;

    typedef struct packed {
        logic [LIMIT_W-1:0] prefix;
        logic [LIMIT_W-1:0] command;
        logic [LIMIT_W-1:0] params;
        logic [LIMIT_W-1:0] trailing;
    } t_limits;

    typedef struct packed {
        t_phase             phase;
        logic [LIMIT_W-1:0] fill;
        logic [COUNT_W-1:0] count;
    } t_parse_state;

endpackage

[rtl/imfs_cfg_regs.sv]
// Field limit registers of the IRC message field splitter.
module imfs_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [imfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [imfs_pkg::LIMIT_W-1:0]    i_cfg_wdata,
    output imfs_pkg::t_limits               o_limits
);

    imfs_pkg::t_limits r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.prefix   <= imfs_pkg::LIMIT_RESET;
            r_limits.command  <= imfs_pkg::LIMIT_RESET;
            r_limits.params   <= imfs_pkg::LIMIT_RESET;
            r_limits.trailing <= imfs_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                imfs_pkg::REG_PREFIX_LIMIT:   r_limits.prefix   <= i_cfg_wdata;
                imfs_pkg::REG_COMMAND_LIMIT:  r_limits.command  <= i_cfg_wdata;
                imfs_pkg::REG_PARAMS_LIMIT:   r_limits.params   <= i_cfg_wdata;
                imfs_pkg::REG_TRAILING_LIMIT: r_limits.trailing <= i_cfg_wdata;
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    assign o_limits = r_limits;

endmodule

[rtl/imfs_classify.sv]
// Per-byte phase resolution, class tagging and next parse state.
module imfs_classify (
    input  logic [imfs_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_end,
    input  imfs_pkg::t_limits            i_limits,
    input  imfs_pkg::t_parse_state       i_state,
    output imfs_pkg::t_parse_state       o_state,
    output imfs_pkg::t_class             o_class,
    output logic [imfs_pkg::COUNT_W-1:0] o_count
);

    logic                        is_colon;
    logic                        is_space;
    imfs_pkg::t_phase            start;
    logic [imfs_pkg::PH_NUM-1:0] take;
    imfs_pkg::t_phase            sel;
    logic                        found;
    logic [imfs_pkg::LIMIT_W-1:0] sel_fill;
    logic [imfs_pkg::COUNT_W-1:0] count_inc;

    assign is_colon = (i_byte == imfs_pkg::CH_COLON);
    assign is_space = (i_byte == imfs_pkg::CH_SPACE);
    // unused phase codes behave as the ended phase
    assign start = (i_state.phase > imfs_pkg::PH_ENDED) ? imfs_pkg::PH_ENDED : i_state.phase;

    // Evaluate every phase on its own: only the entry phase sees the running
    // fill, any phase reached by fall-through starts from an empty field.
    // The colon trailing is entered only by taking its colon, and when it is
    // full it drops straight to the ended phase, past the word trailing.
    always_comb begin
        logic [imfs_pkg::LIMIT_W-1:0] fill_p;
        for (int p = 0; p < imfs_pkg::PH_NUM; p++) begin
            fill_p = (imfs_pkg::PHASE_W'(p) == start) ? i_state.fill : '0;
            case (imfs_pkg::t_phase'(imfs_pkg::PHASE_W'(p)))
                imfs_pkg::PH_START:  take[p] = is_colon;
                imfs_pkg::PH_PREFIX: take[p] = (fill_p < i_limits.prefix) && !is_space;
                imfs_pkg::PH_GAP1:   take[p] = is_space;
                imfs_pkg::PH_CMD:    take[p] = (fill_p < i_limits.command) && !is_space;
                imfs_pkg::PH_GAP2:   take[p] = is_space;
                imfs_pkg::PH_COLON2: take[p] = is_colon;
                imfs_pkg::PH_PARAMS: take[p] = (fill_p < i_limits.params) && !is_space;
                imfs_pkg::PH_GAP3:   take[p] = is_space;
                imfs_pkg::PH_CHOOSE: take[p] = is_colon;
                imfs_pkg::PH_REST:   take[p] = (start == imfs_pkg::PH_REST) &&
                                               (fill_p < i_limits.trailing);
                imfs_pkg::PH_WORD:   take[p] = (start != imfs_pkg::PH_REST) &&
                                               (fill_p < i_limits.trailing) && !is_space;
                imfs_pkg::PH_GAP4:   take[p] = (start != imfs_pkg::PH_REST) && is_space;
                imfs_pkg::PH_COLON4: take[p] = (start != imfs_pkg::PH_REST) && is_colon;
                default:             take[p] = 1'b1;
            endcase
        end
    end

    // First phase at or after the entry phase that takes the byte
    always_comb begin
        sel   = imfs_pkg::PH_ENDED;
        found = 1'b0;
        for (int p = 0; p < imfs_pkg::PH_NUM; p++) begin
            if (!found && (imfs_pkg::PHASE_W'(p) >= start) && take[p]) begin
                sel   = imfs_pkg::t_phase'(imfs_pkg::PHASE_W'(p));
                found = 1'b1;
            end
        end
    end

    assign sel_fill = (sel == start) ? i_state.fill : '0;

    // Output block: class of the byte and the reported count
    always_comb begin
        case (sel)
            imfs_pkg::PH_PREFIX:                     o_class = imfs_pkg::CLS_PREFIX;
            imfs_pkg::PH_CMD:                        o_class = imfs_pkg::CLS_COMMAND;
            imfs_pkg::PH_PARAMS:                     o_class = imfs_pkg::CLS_PARAMS;
            imfs_pkg::PH_REST, imfs_pkg::PH_WORD:    o_class = imfs_pkg::CLS_TRAILING;
            imfs_pkg::PH_ENDED:                      o_class = imfs_pkg::CLS_NONE;
            default:                                 o_class = imfs_pkg::CLS_SKIP;
        endcase
        if (o_class != imfs_pkg::CLS_NONE && i_state.count != imfs_pkg::COUNT_MAX) begin
            count_inc = i_state.count + 1'b1;
        end else begin
            count_inc = i_state.count;
        end
        o_count = i_end ? count_inc : '0;
    end

    // Next-state block
    always_comb begin
        o_state.count = count_inc;
        o_state.fill  = '0;
        case (sel)
            imfs_pkg::PH_START:  o_state.phase = imfs_pkg::PH_PREFIX;
            imfs_pkg::PH_COLON2: o_state.phase = imfs_pkg::PH_PARAMS;
            imfs_pkg::PH_COLON4: o_state.phase = imfs_pkg::PH_ENDED;
            imfs_pkg::PH_CHOOSE: o_state.phase = imfs_pkg::PH_REST;
            imfs_pkg::PH_PREFIX, imfs_pkg::PH_CMD, imfs_pkg::PH_PARAMS,
            imfs_pkg::PH_REST, imfs_pkg::PH_WORD: begin
                o_state.phase = sel;
                o_state.fill  = sel_fill + 1'b1;
            end
            default:             o_state.phase = sel;
        endcase
        // return to the start of a line after its last byte
        if (i_end) begin
            o_state.phase = imfs_pkg::PH_START;
            o_state.fill  = '0;
            o_state.count = '0;
        end
    end

endmodule

[rtl/irc_message_field_splitter.sv]
// An accepted request passes through the input register and then the result register.
// Throughput: one byte per cycle unless stalled; the two registers advance together.
// A stalled result holds, and the input register takes one more byte behind it.
// Reset (i_rst_n low, synchronous): both registers empty, parse at start of line,
// every field limit back to 512.
module irc_message_field_splitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [imfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [imfs_pkg::LIMIT_W-1:0]    i_cfg_wdata,
    // byte request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [imfs_pkg::BYTE_W-1:0]     i_line_byte,
    input  logic                            i_line_end,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [imfs_pkg::BYTE_W-1:0]     o_byte_out,
    output logic [imfs_pkg::CLASS_W-1:0]    o_field_class,
    output logic                            o_message_end,
    output logic [imfs_pkg::COUNT_W-1:0]    o_consumed_count
);

    imfs_pkg::t_limits       limits;
    imfs_pkg::t_parse_state  r_state;
    imfs_pkg::t_parse_state  n_state;
    imfs_pkg::t_class        n_class;
    logic [imfs_pkg::COUNT_W-1:0] n_count;

    // input register
    logic                        r_in_valid;
    logic [imfs_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_end;

    // result register
    logic                         r_out_valid;
    logic [imfs_pkg::BYTE_W-1:0]  r_out_byte;
    imfs_pkg::t_class             r_out_class;
    logic                         r_out_end;
    logic [imfs_pkg::COUNT_W-1:0] r_out_count;

    logic advance;
    logic in_accept;

    imfs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_limits    (limits)
    );

    imfs_classify u_classify (
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .i_limits (limits),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_class  (n_class),
        .o_count  (n_count)
    );

    // Advance the held byte when the result register is empty or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    // Stall new requests only while a held byte cannot move on.
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_line_byte;
            r_in_end  <= i_line_end;
        end
    end

    // Parse state moves only when a byte is resolved into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= imfs_pkg::PH_START;
            r_state.fill  <= '0;
            r_state.count <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result payload while stalled
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte  <= r_in_byte;
            r_out_class <= n_class;
            r_out_end   <= r_in_end;
            r_out_count <= n_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_out       = r_out_byte;
    assign o_field_class    = r_out_class;
    assign o_message_end    = r_out_end;
    assign o_consumed_count = r_out_count;

endmodule
